[hdl/dxt_texture_block_decoder_top_defines.svh]
// ----------------------------------------------------------------------------
// DXT block decoder assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef DXT_TEXTURE_BLOCK_DECODER_TOP_DEFINES_SVH
`define DXT_TEXTURE_BLOCK_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// The antecedent implies the consequent in the same cycle.
`define DXTD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// The antecedent implies the consequent in the following cycle.
`define DXTD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define DXTD_ASSERT_IMPL(name, ante, cons)
`define DXTD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[hdl/dxtd_pkg.sv]
// ----------------------------------------------------------------------------
// DXT block decoder package
// Types, constants and arithmetic helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
package dxtd_pkg;

  // Image and coordinate sizes.
  localparam int MAX_IMAGE_DIM = 4096;
  localparam int DIM_W         = 13;
  localparam int COORD_W       = 12;
  localparam int BLK_POS_W     = 10;
  localparam int BLK_CNT_W     = 11;
  localparam int TEXELS        = 16;
  localparam int SLOT_W        = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Block queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Colour channel positions within a palette entry.
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [1:0] SEL_THIRD    = 2'd3;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } format_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  // One classified block, ready for texel emission.
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic [7:0]           pa3;
    logic [7:0][7:0]      al;
    format_e              fmt;
    logic [63:0]          aw;
    logic [31:0]          cidx;
    logic [COORD_W-1:0]   base_x;
    logic [COORD_W-1:0]   base_y;
    logic [TEXELS-1:0]    mask;
    logic                 final_blk;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Division by three via reciprocal multiply, exact for inputs below 2046.
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[18:11];
  endfunction

  // Division by five via reciprocal multiply, exact for inputs below 2730.
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd1639;
    return p[20:13];
  endfunction

  // Division by seven via reciprocal multiply, exact for inputs below 5466.
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [22:0] p;
    p = 23'(v) * 23'd2341;
    return p[21:14];
  endfunction

  // Zero is taken as one and anything above the maximum is saturated.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_IMAGE_DIM)) begin
      r = DIM_W'(MAX_IMAGE_DIM);
    end
    return r;
  endfunction

endpackage

[hdl/dxtd_front.sv]
// ----------------------------------------------------------------------------
// DXT block decoder front end
// Accepts compressed blocks, tracks block position and builds the palettes.
// ----------------------------------------------------------------------------
module dxtd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dxtd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dxtd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [63:0]                  alpha_word_i,
  input  logic [63:0]                  color_word_i,
  input  dxtd_pkg::fifo_stat_t         q_stat_i,
  output logic                         push_o,
  output dxtd_pkg::blk_t               push_blk_o
);
  import dxtd_pkg::*;

  logic [1:0]           fmt_q;
  logic [DIM_W-1:0]     width_q, height_q;
  logic [BLK_POS_W-1:0] col_q, col_d, row_q, row_d;
  logic                 stg_valid_q, stg_valid_d;
  logic [63:0]          stg_aw_q, stg_cw_q;
  logic [BLK_POS_W-1:0] stg_col_q, stg_row_q;

  logic [DIM_W-1:0]     w_clamp, h_clamp;
  logic [BLK_CNT_W-1:0] cols, rows, col_inc, row_inc;
  logic                 accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_DXT1;
      width_q  <= DIM_W'(4);
      height_q <= DIM_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORMAT: fmt_q    <= cfg_wdata_i[1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Image size in blocks.
  assign w_clamp = clamp_dim(width_q);
  assign h_clamp = clamp_dim(height_q);
  assign cols    = BLK_CNT_W'((w_clamp + DIM_W'(3)) >> 2);
  assign rows    = BLK_CNT_W'((h_clamp + DIM_W'(3)) >> 2);

  // The input stage frees itself whenever its block can move into the queue.
  assign in_stall_o = stg_valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = stg_valid_q && !q_stat_i.full;

  // Raster block position, stepped on every transfer.
  assign col_inc = BLK_CNT_W'(col_q) + BLK_CNT_W'(1);
  assign row_inc = BLK_CNT_W'(row_q) + BLK_CNT_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= cols) begin
        col_d = '0;
        row_d = (row_inc >= rows) ? '0 : row_inc[BLK_POS_W-1:0];
      end else begin
        col_d = col_inc[BLK_POS_W-1:0];
      end
    end
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (push_o) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_aw_q  <= alpha_word_i;
      stg_cw_q  <= color_word_i;
      stg_col_q <= col_q;
      stg_row_q <= row_q;
    end
  end

  // Classify the staged block and build its colour and alpha palettes.
  always_comb begin
    logic [15:0]        c0, c1;
    logic [2:0][7:0]    e0, e1;
    logic [7:0]         a0, a1;
    logic               three;
    logic [COORD_W-1:0] bx, by;
    logic [3:0]         xvis, yvis;

    c0 = stg_cw_q[15:0];
    c1 = stg_cw_q[31:16];
    e0[CH_R] = {c0[15:11], 3'b000};
    e0[CH_G] = {c0[10:5], 2'b00};
    e0[CH_B] = {c0[4:0], 3'b000};
    e1[CH_R] = {c1[15:11], 3'b000};
    e1[CH_G] = {c1[10:5], 2'b00};
    e1[CH_B] = {c1[4:0], 3'b000};

    push_blk_o = '0;
    unique case (fmt_q)
      FMT_DXT1: push_blk_o.fmt = FMT_DXT1;
      FMT_DXT3: push_blk_o.fmt = FMT_DXT3;
      default:  push_blk_o.fmt = FMT_DXT5;
    endcase

    // Three-colour mode exists only in DXT1.
    three = (push_blk_o.fmt == FMT_DXT1) && (c0 <= c1);

    for (int c = 0; c < 3; c++) begin
      push_blk_o.pal[0][c] = e0[c];
      push_blk_o.pal[1][c] = e1[c];
      if (three) begin
        push_blk_o.pal[2][c] = 8'((9'(e0[c]) + 9'(e1[c])) >> 1);
      end else begin
        push_blk_o.pal[2][c] = div3(10'({e0[c], 1'b0}) + 10'(e1[c]) + 10'd1);
      end
      push_blk_o.pal[3][c] = div3(10'(e0[c]) + 10'({e1[c], 1'b0}) + 10'd1);
    end
    push_blk_o.pa3 = three ? ALPHA_CLEAR : ALPHA_OPAQUE;

    // Interpolated alpha, eight-entry or six-entry mode.
    a0 = stg_aw_q[7:0];
    a1 = stg_aw_q[15:8];
    push_blk_o.al[0] = a0;
    push_blk_o.al[1] = a1;
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) begin
        push_blk_o.al[k] = div7(11'(a0) * 11'(8 - k) + 11'(a1) * 11'(k - 1) + 11'd3);
      end
    end else begin
      for (int k = 2; k < 6; k++) begin
        push_blk_o.al[k] = div5(11'(a0) * 11'(6 - k) + 11'(a1) * 11'(k - 1) + 11'd2);
      end
      push_blk_o.al[6] = ALPHA_CLEAR;
      push_blk_o.al[7] = ALPHA_OPAQUE;
    end

    push_blk_o.aw   = stg_aw_q;
    push_blk_o.cidx = stg_cw_q[63:32];

    // Texels inside the image, by column and by row.
    bx = {stg_col_q, 2'b00};
    by = {stg_row_q, 2'b00};
    for (int i = 0; i < 4; i++) begin
      xvis[i] = (DIM_W'(bx) + DIM_W'(i)) < w_clamp;
      yvis[i] = (DIM_W'(by) + DIM_W'(i)) < h_clamp;
    end
    for (int k = 0; k < TEXELS; k++) begin
      push_blk_o.mask[k] = xvis[k % 4] && yvis[k / 4];
    end
    push_blk_o.base_x    = bx;
    push_blk_o.base_y    = by;
    push_blk_o.final_blk = (BLK_CNT_W'(stg_col_q) == cols - BLK_CNT_W'(1)) &&
                           (BLK_CNT_W'(stg_row_q) == rows - BLK_CNT_W'(1));
  end

endmodule

[hdl/dxtd_queue.sv]
// ----------------------------------------------------------------------------
// DXT block decoder block queue
// Short first-in first-out queue of classified blocks between front and back.
// ----------------------------------------------------------------------------
`include "dxt_texture_block_decoder_top_defines.svh"

module dxtd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dxtd_pkg::blk_t       push_blk_i,
  input  logic                 pop_i,
  output dxtd_pkg::blk_t       head_o,
  output dxtd_pkg::fifo_stat_t stat_o
);
  import dxtd_pkg::*;

  blk_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_blk_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // The front must never push into a full queue, nor the back pop an empty one.
  `DXTD_ASSERT_IMPL(q_no_overflow_a, push_i, !stat_o.full)
  `DXTD_ASSERT_IMPL(q_no_underflow_a, pop_i, !stat_o.empty)
  `DXTD_ASSERT_NEXT(q_push_fills_a, push_i && !pop_i, !stat_o.empty)

endmodule

[hdl/dxtd_back.sv]
// ----------------------------------------------------------------------------
// DXT block decoder back end
// Walks the queue head's texels; one decoded texel a cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "dxt_texture_block_decoder_top_defines.svh"

module dxtd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dxtd_pkg::blk_t                head_i,
  input  dxtd_pkg::fifo_stat_t          stat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic [7:0]                    alpha_o,
  output logic [dxtd_pkg::COORD_W-1:0]  pixel_x_o,
  output logic [dxtd_pkg::COORD_W-1:0]  pixel_y_o,
  output logic                          block_last_o,
  output logic                          image_last_o
);
  import dxtd_pkg::*;

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               out_valid_q;
  logic [7:0]         red_q, green_q, blue_q, alpha_q;
  logic [COORD_W-1:0] px_q, py_q;
  logic               blast_q, ilast_q;

  logic               head_valid, adv, emit, done;
  logic [1:0]         sel;
  logic [3:0]         nib;
  logic [2:0]         aidx;
  logic [5:0]         aoff;
  logic [7:0]         alpha;

  assign head_valid = !stat_i.empty;
  // The output register takes a new texel when empty or when the current one transfers.
  assign adv        = !out_valid_q || !out_stall_i;

  // Per-texel index fields of the current slot.
  assign sel  = head_i.cidx[{slot_q, 1'b0} +: 2];
  assign nib  = head_i.aw[{slot_q, 2'b00} +: 4];
  assign aoff = 6'd16 + 6'({slot_q, 1'b0}) + 6'(slot_q);
  assign aidx = head_i.aw[aoff +: 3];

  // Alpha by format.
  always_comb begin
    unique case (head_i.fmt)
      FMT_DXT1: alpha = (sel == SEL_THIRD) ? head_i.pa3 : ALPHA_OPAQUE;
      FMT_DXT3: alpha = {nib, nib};
      default:  alpha = head_i.al[aidx];
    endcase
  end

  // The block is finished once no visible texel lies beyond this slot.
  assign done  = (head_i.mask & (16'hFFFE << slot_q)) == '0;
  assign emit  = head_valid && adv && head_i.mask[slot_q];
  assign pop_o = head_valid && adv && done;

  always_comb begin
    slot_d = slot_q;
    if (pop_o) begin
      slot_d = '0;
    end else if (head_valid && adv) begin
      slot_d = slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  // Output texel register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      red_q   <= head_i.pal[sel][CH_R];
      green_q <= head_i.pal[sel][CH_G];
      blue_q  <= head_i.pal[sel][CH_B];
      alpha_q <= alpha;
      px_q    <= head_i.base_x + COORD_W'(slot_q[1:0]);
      py_q    <= head_i.base_y + COORD_W'(slot_q[3:2]);
      blast_q <= done;
      ilast_q <= done && head_i.final_blk;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign alpha_o      = alpha_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign block_last_o = blast_q;
  assign image_last_o = ilast_q;

  // Image end is always a block end; a finished block restarts at slot zero.
  `DXTD_ASSERT_IMPL(bk_image_last_a, out_valid_o && image_last_o, block_last_o)
  `DXTD_ASSERT_IMPL(bk_pop_has_block_a, pop_o, head_valid)
  `DXTD_ASSERT_NEXT(bk_slot_restart_a, pop_o, slot_q == '0)

endmodule

[hdl/dxt_texture_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// DXT texture block decoder top level
// Path: a block is staged, queued, then its texels are registered at the output.
// Throughput: one texel a cycle while the texel port is not stalled.
// Reset: block position clears to zero, format to DXT1, image size to 4 by 4.
// ----------------------------------------------------------------------------
module dxt_texture_block_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dxtd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dxtd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [63:0]                     alpha_word_i,
  input  logic [63:0]                     color_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic [dxtd_pkg::COORD_W-1:0]    pixel_x_o,
  output logic [dxtd_pkg::COORD_W-1:0]    pixel_y_o,
  output logic                            block_last_o,
  output logic                            image_last_o
);
  import dxtd_pkg::*;

  logic       push, pop;
  blk_t       push_blk, head_blk;
  fifo_stat_t q_stat;

  // Front end: block transfer, position tracking and palette build.
  dxtd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .alpha_word_i (alpha_word_i),
    .color_word_i (color_word_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_blk_o   (push_blk)
  );

  // Queue of classified blocks.
  dxtd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_blk_i (push_blk),
    .pop_i      (pop),
    .head_o     (head_blk),
    .stat_o     (q_stat)
  );

  // Back end: texel emission.
  dxtd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_blk),
    .stat_i       (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .block_last_o (block_last_o),
    .image_last_o (image_last_o)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DXT texture block decoder testbench
// Sends compressed 4x4 blocks in DXT1, DXT3 and DXT5 over a range of image
// sizes, predicts every decoded texel and its position in the image, and
// checks each texel transfer against the oldest prediction. Both ports idle
// and stall at random, and the texel port is held off once for a long
// stretch so that the decoder backs up onto its block input.
// ----------------------------------------------------------------------------
module testbench;
  import dxtd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Format code with no name of its own; the decoder treats it as DXT5.
  localparam logic [1:0]  FMT_SPARE    = 2'd3;

  // One decoded texel as it leaves the decoder.
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               blk_last;
    logic               img_last;
  } texel_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [63:0]           alpha_word;
  logic [63:0]           color_word;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [7:0]            alpha;
  logic [COORD_W-1:0]    pixel_x;
  logic [COORD_W-1:0]    pixel_y;
  logic                  block_last;
  logic                  image_last;

  // Predictor copy of the registers and of the block position.
  logic [1:0]            fmt_q     = FMT_DXT1;
  logic [DIM_W-1:0]      width_q   = DIM_W'(4);
  logic [DIM_W-1:0]      height_q  = DIM_W'(4);
  int unsigned           blk_col   = 0;
  int unsigned           blk_row   = 0;

  texel_t                expected_texels[$];
  int unsigned           mismatch_count = 0;
  bit                    idle_on        = 1'b1;
  int unsigned           hold_left      = 0;
  int unsigned           stall_run      = 0;

  dxt_texture_block_decoder_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .alpha_word_i (alpha_word),
    .color_word_i (color_word),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue),
    .alpha_o      (alpha),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .block_last_o (block_last),
    .image_last_o (image_last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Image dimension as the decoder uses it: zero reads as one, large values saturate.
  function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end else if (v > DIM_W'(MAX_IMAGE_DIM)) begin
      return MAX_IMAGE_DIM;
    end
    return v;
  endfunction

  // Decode one block at the current position, queue its texels and advance.
  task automatic decode_block(input logic [63:0] aw, input logic [63:0] cw);
    int unsigned w, h, cols, rows, c0, c1, k, sel, px, py, av, a0, a1;
    int unsigned pr[4], pg[4], pb[4], pa[4], al[8];
    texel_t      t;
    texel_t      blk_q[$];
    w    = fit_dim(width_q);
    h    = fit_dim(height_q);
    cols = (w + 3) / 4;
    rows = (h + 3) / 4;
    c0   = cw[15:0];
    c1   = cw[31:16];

    // Endpoints widened by shifting alone.
    pr[0] = ((c0 >> 11) & 32'h1F) << 3;
    pg[0] = ((c0 >> 5) & 32'h3F) << 2;
    pb[0] = (c0 & 32'h1F) << 3;
    pr[1] = ((c1 >> 11) & 32'h1F) << 3;
    pg[1] = ((c1 >> 5) & 32'h3F) << 2;
    pb[1] = (c1 & 32'h1F) << 3;
    pa[0] = 8'hFF;
    pa[1] = 8'hFF;
    pa[2] = 8'hFF;

    // Three-colour mode only in DXT1 with colour0 not above colour1.
    if (fmt_q != FMT_DXT1 || c0 > c1) begin
      pr[2] = (2 * pr[0] + pr[1] + 1) / 3;
      pg[2] = (2 * pg[0] + pg[1] + 1) / 3;
      pb[2] = (2 * pb[0] + pb[1] + 1) / 3;
      pa[3] = 8'hFF;
    end else begin
      pr[2] = (pr[0] + pr[1]) / 2;
      pg[2] = (pg[0] + pg[1]) / 2;
      pb[2] = (pb[0] + pb[1]) / 2;
      pa[3] = 8'h00;
    end
    pr[3] = (pr[0] + 2 * pr[1] + 1) / 3;
    pg[3] = (pg[0] + 2 * pg[1] + 1) / 3;
    pb[3] = (pb[0] + 2 * pb[1] + 1) / 3;

    // Interpolated alpha table, eight-entry or six-entry.
    a0    = aw[7:0];
    a1    = aw[15:8];
    al[0] = a0;
    al[1] = a1;
    if (a0 > a1) begin
      for (k = 2; k < 8; k++) begin
        al[k] = ((8 - k) * a0 + (k - 1) * a1 + 3) / 7;
      end
    end else begin
      for (k = 2; k < 6; k++) begin
        al[k] = ((6 - k) * a0 + (k - 1) * a1 + 2) / 5;
      end
      al[6] = 8'h00;
      al[7] = 8'hFF;
    end

    // Texels in raster order inside the block, clipped to the image.
    for (k = 0; k < 16; k++) begin
      px  = blk_col * 4 + (k % 4);
      py  = blk_row * 4 + (k / 4);
      sel = cw[32 + 2 * k +: 2];
      if (px < w && py < h) begin
        if (fmt_q == FMT_DXT1) begin
          av = pa[sel];
        end else if (fmt_q == FMT_DXT3) begin
          av = 17 * aw[4 * k +: 4];
        end else begin
          av = al[aw[16 + 3 * k +: 3]];
        end
        t.red      = 8'(pr[sel]);
        t.green    = 8'(pg[sel]);
        t.blue     = 8'(pb[sel]);
        t.alpha    = 8'(av);
        t.px       = COORD_W'(px);
        t.py       = COORD_W'(py);
        t.blk_last = 1'b0;
        t.img_last = 1'b0;
        blk_q.push_back(t);
      end
    end
    if (blk_q.size() != 0) begin
      blk_q[blk_q.size() - 1].blk_last = 1'b1;
      blk_q[blk_q.size() - 1].img_last = (blk_col == cols - 1) && (blk_row == rows - 1);
    end
    foreach (blk_q[i]) begin
      expected_texels.push_back(blk_q[i]);
    end

    // Raster block order, wrapping to a new image after the final block.
    if (blk_col + 1 >= cols) begin
      blk_col = 0;
      if (blk_row + 1 >= rows) begin
        blk_row = 0;
      end else begin
        blk_row++;
      end
    end else begin
      blk_col++;
    end
  endtask

  // Report one mismatch on a line of its own and count it.
  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want, input texel_t ref_t);
    if (got != want) begin
      note_mismatch($sformatf("%s of texel (%0d,%0d): got %0h, expected %0h",
                              name, ref_t.px, ref_t.py, got, want));
    end
  endtask

  // Check each texel transfer against the oldest prediction.
  always @(posedge clk) begin
    texel_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_texels.size() == 0) begin
        note_mismatch($sformatf("texel (%0d,%0d) with none expected", pixel_x, pixel_y));
      end else begin
        want = expected_texels.pop_front();
        compare_field("red", red, want.red, want);
        compare_field("green", green, want.green, want);
        compare_field("blue", blue, want.blue, want);
        compare_field("alpha", alpha, want.alpha, want);
        compare_field("pixel_x", pixel_x, want.px, want);
        compare_field("pixel_y", pixel_y, want.py, want);
        compare_field("block_last", block_last, want.blk_last, want);
        compare_field("image_last", image_last, want.img_last, want);
      end
    end
  end

  // Texel port stall: a long hold-off when requested, else random bursts while idle_on.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one block, sometimes after a random gap, and predict it on its transfer.
  task automatic send_block(input logic [63:0] aw, input logic [63:0] cw);
    int unsigned gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    alpha_word <= aw;
    color_word <= cw;
    do @(posedge clk); while (in_stall);
    decode_block(aw, cw);
  endtask

  // Register write; the predictor takes the new value at once as the decoder is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FORMAT: fmt_q    = value[1:0];
      REG_WIDTH:  width_q  = value;
      REG_HEIGHT: height_q = value;
      default: ;
    endcase
  endtask

  // Stop offering blocks, wait for every texel, then let blocks with no texels drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random block, often steered into three-colour, equal-endpoint or six-entry alpha cases.
  task automatic random_block(output logic [63:0] aw, output logic [63:0] cw);
    logic [15:0] c0, c1;
    logic [7:0]  a0, a1;
    aw = {$urandom, $urandom};
    cw = {$urandom, $urandom};
    c0 = cw[15:0];
    c1 = cw[31:16];
    a0 = aw[7:0];
    a1 = aw[15:8];
    case ($urandom_range(0, 3))
      0: if (c0 > c1) cw[31:0] = {c0, c1};
      1: cw[31:16] = c0;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: if (a0 > a1) aw[15:0] = {a0, a1};
      1: aw[15:8] = a0;
      default: ;
    endcase
  endtask

  // Image dimension, mostly small, sometimes zero, the maximum or beyond it.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'(MAX_IMAGE_DIM);
      2:       return DIM_W'($urandom_range(MAX_IMAGE_DIM + 1, 8191));
      3:       return DIM_W'($urandom_range(1, MAX_IMAGE_DIM));
      default: return DIM_W'($urandom_range(1, 16));
    endcase
  endfunction

  // DXT1 at the reset settings: four-colour, three-colour and equal endpoints.
  task automatic test_dxt1_colour_modes();
    send_block(64'h0, 64'h0);
    send_block(64'h0, 64'hE4E4E4E4_0000FFFF);
    send_block(64'h0, 64'hE4E4E4E4_FFFF0000);
    send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
    send_block({$urandom, $urandom}, {$urandom, 32'h07E0F800});
  endtask

  // DXT3 explicit alpha; colour stays four-colour whatever the endpoint order.
  task automatic test_dxt3_explicit_alpha();
    wait_idle();
    write_reg(REG_FORMAT, CFG_DATA_W'(FMT_DXT3));
    send_block(64'h0, 64'hE4E4E4E4_FFFF0000);
    send_block(64'hFFFFFFFF_FFFFFFFF, 64'h1B1B1B1B_0000FFFF);
    send_block(64'h01234567_89ABCDEF, {$urandom, 32'h5555_5555});
  endtask

  // DXT5 interpolated alpha in both table modes, every index, and the spare code.
  task automatic test_dxt5_interpolated_alpha();
    logic [47:0] idx_all;
    int unsigned k;
    for (k = 0; k < 16; k++) begin
      idx_all[3 * k +: 3] = 3'(k);
    end
    wait_idle();
    write_reg(REG_FORMAT, CFG_DATA_W'(FMT_DXT5));
    send_block({idx_all, 8'h20, 8'hE0}, 64'hE4E4E4E4_0000FFFF);
    send_block({idx_all, 8'hE0, 8'h20}, 64'hE4E4E4E4_FFFF0000);
    send_block({idx_all, 8'h00, 8'hFF}, 64'h1B1B1B1B_1234ABCD);
    send_block({idx_all, 16'h0000}, {$urandom, $urandom});
    wait_idle();
    write_reg(REG_FORMAT, CFG_DATA_W'(FMT_SPARE));
    send_block({idx_all, 8'h11, 8'h99}, {$urandom, $urandom});
  endtask

  // Clipping at odd sizes, zero and oversize dimensions, and a block wholly outside.
  task automatic test_image_clipping();
    int unsigned k;
    wait_idle();
    write_reg(REG_FORMAT, CFG_DATA_W'(FMT_DXT1));
    write_reg(REG_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_HEIGHT, CFG_DATA_W'(6));
    for (k = 0; k < 4; k++) begin
      send_block({$urandom, $urandom}, {$urandom, $urandom});
    end
    wait_idle();
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, '0);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    wait_idle();
    write_reg(REG_WIDTH, '1);
    write_reg(REG_HEIGHT, '1);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    // Shrinking the image leaves the position beyond its last column.
    wait_idle();
    write_reg(REG_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_HEIGHT, CFG_DATA_W'(4));
    send_block({$urandom, $urandom}, {$urandom, $urandom});
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Hold the texel port off while blocks keep coming, so the input backs up.
  task automatic test_output_hold_off();
    logic [63:0] aw, cw;
    int unsigned k;
    wait_idle();
    write_reg(REG_WIDTH, CFG_DATA_W'(64));
    write_reg(REG_HEIGHT, CFG_DATA_W'(64));
    idle_on = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 10; k++) begin
      random_block(aw, cw);
      send_block(aw, cw);
    end
    idle_on = 1'b1;
  endtask

  // Random blocks in phases of random settings; the last phase runs with no idling.
  task automatic test_random_blocks(input int unsigned phases, input int unsigned per_phase);
    logic [63:0] aw, cw;
    int unsigned p, k;
    for (p = 0; p < phases; p++) begin
      wait_idle();
      write_reg(REG_FORMAT, CFG_DATA_W'($urandom_range(0, 3)));
      write_reg(REG_WIDTH, pick_dim());
      write_reg(REG_HEIGHT, pick_dim());
      if (p == phases - 1) begin
        idle_on = 1'b0;
      end
      for (k = 0; k < per_phase; k++) begin
        random_block(aw, cw);
        send_block(aw, cw);
      end
    end
  endtask

  // Main sequence: reset, directed tests, random traffic, drain and verdict.
  initial begin
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_FORMAT;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    alpha_word = '0;
    color_word = '0;
    out_stall  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_dxt1_colour_modes();
    test_dxt3_explicit_alpha();
    test_dxt5_interpolated_alpha();
    test_image_clipping();
    test_output_hold_off();
    test_random_blocks(5, 30);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/dxtd_pkg.sv
hdl/dxtd_front.sv
hdl/dxtd_queue.sv
hdl/dxtd_back.sv
hdl/dxt_texture_block_decoder_top.sv
bench/testbench.sv
